// File: sv/kde_pkg.sv
`default_nettype none
package kde_pkg;

  localparam int DIMS_DEF       = 4;
  localparam int MAX_POINTS_DEF = 1048576;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int SUM_W   = 37;
  localparam int PCNT_W  = 21;
  localparam int DENS_W  = 16;
  localparam int INV_W   = 32;
  localparam int TERMS   = 12;

  localparam logic [2:0] CFG_QUERY0 = 3'd0;
  localparam logic [2:0] CFG_QUERY1 = 3'd1;
  localparam logic [2:0] CFG_QUERY2 = 3'd2;
  localparam logic [2:0] CFG_QUERY3 = 3'd3;
  localparam logic [2:0] CFG_INV    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D2M,
    S_D2A,
    S_ARGM,
    S_ARGC,
    S_TM,
    S_TR,
    S_TC,
    S_SQM,
    S_SQR,
    S_ACC,
    S_DIVS,
    S_DIV,
    S_EMIT
  } back_state_t;

  // floor(2^32 / k) for the Taylor term divisors
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/gaussian_kde_point_sum.sv
// Back end: each point is stepped through the single shared 32x32
// multiplier for the distance, the 12 Taylor terms and four squarings,
// ending early when the kernel is cut to zero.
// A last point adds the 16-step mean division (skipped when the mean
// saturates) and the output load, plus any output stall.
// A new point starts only after the last; a two-beat queue decouples input.
// Reset (rst, synchronous): sum and count clear, queries 0, inv_two_h_sq 1.0.
`default_nettype none
module gaussian_kde_point_sum #(
  parameter int DIMS       = kde_pkg::DIMS_DEF,
  parameter int MAX_POINTS = kde_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // dim0_value, dim1_value, dim2_value, dim3_value
  input  wire logic        s_tlast,  // last_point
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // density, points_used, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import kde_pkg::*;

  logic [4*COORD_W-1:0]    query;
  logic [INV_W-1:0]        inv;
  logic                    q_valid;
  logic                    q_pop;
  logic [DIMS*DIFF_W:0]    q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query <= '0;
      inv   <= 32'h0001_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUERY0: query[0*COORD_W +: COORD_W] <= cfg_data[15:0];
        CFG_QUERY1: query[1*COORD_W +: COORD_W] <= cfg_data[15:0];
        CFG_QUERY2: query[2*COORD_W +: COORD_W] <= cfg_data[15:0];
        CFG_QUERY3: query[3*COORD_W +: COORD_W] <= cfg_data[15:0];
        CFG_INV:    inv <= cfg_data;
        default: ;
      endcase
    end
  end

  kde_front #(.DIMS(DIMS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .query    (query),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  kde_back #(.DIMS(DIMS), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data),
    .inv      (inv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// File: sv/kde_front.sv
`default_nettype none
module kde_front #(
  parameter int DIMS = kde_pkg::DIMS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [4*kde_pkg::COORD_W-1:0]        s_tdata,
  input  wire logic                                 s_tlast,
  input  wire logic [4*kde_pkg::COORD_W-1:0]        query,
  output logic                                      q_valid,
  input  wire logic                                 q_pop,
  output logic [DIMS*kde_pkg::DIFF_W:0]             q_data
);
  import kde_pkg::*;

  localparam int ENT_W = DIMS * DIFF_W + 1;

  logic [ENT_W-1:0] entry;
  logic [ENT_W-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      entry[i*DIFF_W +: DIFF_W] =
        {s_tdata[i*COORD_W + COORD_W-1], s_tdata[i*COORD_W +: COORD_W]} -
        {query[i*COORD_W + COORD_W-1], query[i*COORD_W +: COORD_W]};
    end
    entry[ENT_W-1] = s_tlast;
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule
`default_nettype wire

// File: sv/kde_back.sv
`default_nettype none
module kde_back #(
  parameter int DIMS       = kde_pkg::DIMS_DEF,
  parameter int MAX_POINTS = kde_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [DIMS*kde_pkg::DIFF_W:0] q_data,
  input  wire logic [kde_pkg::INV_W-1:0]     inv,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [39:0]                        m_tdata
);
  import kde_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int WIDE  = SUM_W + CNT_W + 16;

  back_state_t state, state_next;

  logic signed [DIFF_W-1:0] diff [DIMS];
  logic                     last;
  logic [DW-1:0]            dcnt;
  logic [33:0]              d2;
  logic [63:0]              prod;
  logic [31:0]              mul_a, mul_b;
  logic [30:0]              xv;
  logic [31:0]              term;
  logic signed [33:0]       tsum;
  logic [30:0]              vv;
  logic [3:0]               k;
  logic [1:0]               sqn;
  logic [31:0]              e;
  logic [16:0]              kern;
  logic [SUM_W-1:0]         ksum;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         rem;
  logic [3:0]               bitn;
  logic [DENS_W-1:0]        quo;
  logic [DENS_W-1:0]        density;
  logic [PCNT_W-1:0]        points_used;

  logic [DIFF_W-1:0]        dsel;
  logic [15:0]              mag;
  logic [30:0]              qe;
  logic [31:0]              rr;
  logic [30:0]              qv;
  logic signed [33:0]       tsum_new;
  logic [31:0]              e_clamp;
  logic [31:0]              e_sq;
  logic [CNT_W:0]           trial;
  logic [WIDE-1:0]          sum_wide;
  logic [WIDE-1:0]          cnt_wide;
  logic                     out_free;

  assign dsel     = diff[dcnt];
  assign mag      = dsel[DIFF_W-1] ? 16'(-dsel) : dsel[15:0];
  assign qe       = prod[62:32];
  assign rr       = 32'(vv) - 32'(qe) * 32'(k);
  assign qv       = (state == S_TR) ? prod[61:31] : ((rr >= 32'(k)) ? qe + 31'd1 : qe);
  assign tsum_new = k[0] ? tsum - 34'(qv) : tsum + 34'(qv);
  assign e_clamp  = tsum_new[33] ? 32'd0 :
                    (tsum_new > 34'sh8000_0000) ? 32'h8000_0000 : tsum_new[31:0];
  assign e_sq     = 32'((prod + 64'h4000_0000) >> 31);
  assign trial    = {rem, ksum[bitn]};
  assign sum_wide = WIDE'(ksum);
  assign cnt_wide = WIDE'(cnt) << 16;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_D2M: begin
        mul_a = 32'(mag);
        mul_b = 32'(mag);
      end
      S_ARGM: begin
        mul_a = 32'(d2[19:0]);
        mul_b = inv;
      end
      S_TM: begin
        mul_a = term;
        mul_b = 32'(xv);
      end
      S_TR: begin
        mul_a = 32'(prod[61:31]);
        mul_b = recip(k);
      end
      S_SQM: begin
        mul_a = e;
        mul_b = e;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_D2M;
      S_D2M:  state_next = S_D2A;
      S_D2A:  state_next = (dcnt == DW'(DIMS - 1)) ? S_ARGM : S_D2M;
      S_ARGM: state_next = (inv != '0 && d2 >= 34'h10_0000) ? S_ACC : S_ARGC;
      S_ARGC: state_next = (prod >= 64'h10_0000) ? S_ACC : S_TM;
      S_TM:   state_next = S_TR;
      S_TR:   state_next = (k == 4'd1) ? S_TM : S_TC;
      S_TC:   state_next = (k == 4'(TERMS)) ? S_SQM : S_TM;
      S_SQM:  state_next = S_SQR;
      S_SQR:  state_next = (sqn == 2'd3) ? S_ACC : S_SQM;
      S_ACC:  state_next = last ? S_DIVS : S_IDLE;
      S_DIVS: state_next = (cnt == '0 || sum_wide >= cnt_wide) ? S_EMIT : S_DIV;
      S_DIV:  state_next = (bitn == 4'd0) ? S_EMIT : S_DIV;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ksum     <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_ACC && cnt < CNT_W'(MAX_POINTS)) begin
        ksum <= ksum + SUM_W'(kern);
        cnt  <= cnt + CNT_W'(1);
      end
      if (state == S_EMIT && out_free) begin
        ksum     <= '0;
        cnt      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        for (int i = 0; i < DIMS; i++) diff[i] <= q_data[i*DIFF_W +: DIFF_W];
        last <= q_data[DIMS*DIFF_W];
        dcnt <= '0;
        d2   <= '0;
      end
      S_D2A: begin
        d2   <= d2 + prod[33:0];
        dcnt <= dcnt + DW'(1);
      end
      S_ARGM: kern <= 17'd0;
      S_ARGC: begin
        xv   <= {prod[19:0], 11'd0};
        term <= 32'h8000_0000;
        tsum <= 34'sh8000_0000;
        k    <= 4'd1;
      end
      S_TR: begin
        vv <= prod[61:31];
        if (k == 4'd1) begin
          term <= 32'(qv);
          tsum <= tsum_new;
          k    <= k + 4'd1;
        end
      end
      S_TC: begin
        term <= 32'(qv);
        tsum <= tsum_new;
        k    <= k + 4'd1;
        e    <= e_clamp;
        sqn  <= 2'd0;
      end
      S_SQR: begin
        e    <= e_sq;
        sqn  <= sqn + 2'd1;
        kern <= 17'((e_sq + 32'h4000) >> 15);
      end
      S_DIVS: begin
        quo  <= (cnt == '0) ? '0 : {DENS_W{1'b1}};
        rem  <= CNT_W'(sum_wide >> 16);
        bitn <= 4'd15;
      end
      S_DIV: begin
        bitn <= bitn - 4'd1;
        quo  <= {quo[DENS_W-2:0], trial >= {1'b0, cnt}};
        rem  <= (trial >= {1'b0, cnt}) ? CNT_W'(trial - {1'b0, cnt}) : CNT_W'(trial);
      end
      S_EMIT: begin
        if (out_free) begin
          density     <= quo;
          points_used <= PCNT_W'(cnt);
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {3'd0, points_used, density};

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_POINTS)) else $error("point count above limit");
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < cnt) else $error("divider remainder out of range");
  a_kern_max: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> kern <= 17'h1_0000) else $error("kernel above one");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> m_tvalid && state == S_IDLE)
    else $error("result not presented");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import kde_pkg::*;

  localparam int NDIM   = 4;
  localparam int MAXPTS = 1048576;
  localparam int N_RAND = 930;
  localparam longint LIMIT = 3000000;
  localparam logic [2:0] CFG_BAD_LO = 3'd5;
  localparam logic [2:0] CFG_BAD_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  gaussian_kde_point_sum u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [20:0] pts;
    logic [15:0] dens;
  } estimate_t;

  typedef struct {
    logic signed [15:0] c [4];
    logic               last;
    logic               fixed;
    estimate_t          want;
  } point_row_t;

  logic signed [15:0] qry [4];
  logic [31:0]        inv_h;
  logic [36:0]        ksum;
  logic [20:0]        kcnt;
  estimate_t          pending [$];
  int                 errors;
  bit                 quiet;
  bit                 hold_long;
  longint             cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [16:0] kernel(input logic [63:0] d2, input logic [31:0] inv);
    logic [63:0] arg, x, term, e;
    longint      acc;
    if (inv != 0 && d2 >= 64'd1048576) return 17'd0;
    arg = d2 * inv;
    if (arg >= 64'd1048576) return 17'd0;
    x = arg << 11;
    term = 64'd1 << 31;
    acc = longint'(64'd1 << 31);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x) >> 31) / k;
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    e = 64'(acc);
    if (e > (64'd1 << 31)) e = 64'd1 << 31;
    for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 30)) >> 31;
    return 17'((e + (64'd1 << 14)) >> 15);
  endfunction

  function automatic bit accumulate(input logic signed [15:0] c [4], input logic lst,
                                    output estimate_t est);
    logic [63:0] d2;
    longint      df;
    logic [63:0] mean;
    d2 = 0;
    for (int i = 0; i < NDIM; i++) begin
      df = longint'(c[i]) - longint'(qry[i]);
      if (df < 0) df = -df;
      d2 += 64'(df) * 64'(df);
    end
    if (kcnt < MAXPTS) begin
      ksum = ksum + 37'(kernel(d2, inv_h));
      kcnt++;
    end
    if (!lst) return 0;
    mean = kcnt != 0 ? 64'(ksum) / 64'(kcnt) : 64'd0;
    est.dens = mean > 65535 ? 16'hFFFF : mean[15:0];
    est.pts = kcnt;
    ksum = 0;
    kcnt = 0;
    return 1;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_INV) qry[idx] = val[15:0];
    else if (idx == CFG_INV) inv_h = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(3) == 0) repeat ($urandom_range(1, 14)) @(negedge clk);
  endtask

  task automatic send(input logic signed [15:0] c [4], input logic lst, input bit fixed,
                      input estimate_t want);
    estimate_t est;
    idle_gap();
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata  <= {c[3], c[2], c[1], c[0]};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    if (accumulate(c, lst, est)) begin
      if (fixed && est != want) begin
        $error("table row: expected %0d/%0d, predictor %0d/%0d",
               want.dens, want.pts, est.dens, est.pts);
        errors++;
      end
      pending.insert(pending.size(), est);
    end
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_point(input int mode);
    logic signed [15:0] c [4];
    estimate_t nul;
    nul = '0;
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0:       c[i] = qry[i] + 16'($signed($urandom_range(0, 600)) - 300);
        1:       c[i] = qry[i] + 16'($signed($urandom_range(0, 8)) - 4);
        default: c[i] = 16'($urandom);
      endcase
    end
    send(c, $urandom_range(5) == 0, 0, nul);
  endtask

  always @(posedge clk) begin
    estimate_t got, exp_e;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[36:0];
      if (pending.size() == 0) begin
        $error("unexpected estimate density=%0d points=%0d", got.dens, got.pts);
        errors++;
      end else begin
        exp_e = pending.pop_front();
        if (got.dens != exp_e.dens) begin
          $error("density: expected %0d, actual %0d", exp_e.dens, got.dens);
          errors++;
        end
        if (got.pts != exp_e.pts) begin
          $error("points_used: expected %0d, actual %0d", exp_e.pts, got.pts);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        m_tready <= 0;
        n = 0;
        while (n < 1500) begin
          @(negedge clk);
          n++;
        end
        hold_long = 0;
      end else if (!quiet && $urandom_range(4) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        m_tready <= 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    point_row_t rows [$];
    point_row_t r;
    logic signed [15:0] c [4];
    estimate_t nul;
    int n;
    cycles = 0;
    errors = 0;
    quiet = 0;
    hold_long = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tlast = 0;
    m_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) qry[i] = 0;
    inv_h = 32'd65536;
    ksum = 0;
    kcnt = 0;
    nul = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // at query: kernel 1.0, mean saturates
    r.c = '{0, 0, 0, 0}; r.last = 1; r.fixed = 1; r.want = '{pts: 1, dens: 16'hFFFF};
    rows.insert(rows.size(), r);
    // far point: kernel 0
    r.c = '{-32768, 32767, -32768, 32767}; r.want = '{pts: 1, dens: 0};
    rows.insert(rows.size(), r);
    r.c = '{32767, 0, 0, 0}; r.last = 0; r.fixed = 0; rows.insert(rows.size(), r);
    r.c = '{1, 0, 0, 0}; rows.insert(rows.size(), r);
    r.c = '{0, -1, 1, 0}; rows.insert(rows.size(), r);
    r.c = '{2, 2, -2, 1}; r.last = 1; rows.insert(rows.size(), r);
    r.c = '{0, 0, 0, 4}; r.last = 0; rows.insert(rows.size(), r);
    r.c = '{3, 0, 0, 0}; r.last = 1; rows.insert(rows.size(), r);
    foreach (rows[i]) send(rows[i].c, rows[i].last, rows[i].fixed, rows[i].want);
    drain();

    // zero bandwidth term: every kernel is 1.0
    cfg_write(CFG_INV, 32'd0);
    cfg_write(CFG_QUERY0, 32'h0000_8000);
    cfg_write(CFG_QUERY3, 32'h0000_7FFF);
    rows.delete();
    r.c = '{32767, -32768, 32767, -32768}; r.last = 0; r.fixed = 0;
    rows.insert(rows.size(), r);
    r.last = 1; r.fixed = 1; r.want = '{pts: 2, dens: 16'hFFFF};
    rows.insert(rows.size(), r);
    foreach (rows[i]) send(rows[i].c, rows[i].last, rows[i].fixed, rows[i].want);
    drain();

    // max bandwidth term and bad register indices
    cfg_write(CFG_INV, 32'hFFFF_FFFF);
    cfg_write(CFG_BAD_HI, 32'h1234_5678);
    cfg_write(CFG_BAD_LO, 32'h0000_0001);
    c = '{-32768, 0, 0, 32767};
    send(c, 0, 0, nul);
    c = '{-32767, 0, 0, 32767};
    send(c, 1, 0, nul);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_QUERY0, $urandom);
      cfg_write(CFG_QUERY1, $urandom);
      cfg_write(CFG_QUERY2, $urandom);
      cfg_write(CFG_QUERY3, $urandom);
      case (ph)
        0: cfg_write(CFG_INV, $urandom_range(1, 400));
        1: cfg_write(CFG_INV, $urandom_range(1, 20));
        2: cfg_write(CFG_INV, $urandom_range(1000, 70000));
        3: cfg_write(CFG_INV, $urandom);
        default: cfg_write(CFG_INV, 32'd65536);
      endcase
      if (ph == 2) hold_long = 1;
      if (ph == 4) quiet = 1;
      n = 0;
      while (n < N_RAND / 5) begin
        random_point(ph == 2 ? 1 : ($urandom_range(9) == 0 ? 2 : ($urandom_range(1))));
        n++;
      end
      c = '{0, 0, 0, 0};
      send(c, 1, 0, nul);
      drain();
    end

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
